FILE: rtl/lbnsm_pkg.sv
package lbnsm_pkg;

  localparam int PANEL_W = 640;
  localparam int PANEL_H = 480;

  localparam int XW   = 10;
  localparam int YW   = 9;
  localparam int SW   = 12;
  localparam int LW   = 24;
  localparam int QW   = 22;
  localparam int NCELL = QW;
  localparam int LAT  = 2 * NCELL + 4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SIZE  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [QW-1:0] qd;
    logic [SW-1:0] dv;
  } lane_t;

  typedef struct packed {
    logic          vld;
    logic          in_pic;
    logic [XW-1:0] px;
    logic [YW-1:0] py;
  } sb_t;

endpackage

FILE: rtl/letterbox_nearest_scaler_map_unit.sv
// channel | signals                          | handshake
// request | start, busy, panel_x, panel_y    | taken when start && !busy
// result  | done, status, inside_res, src_*  | one-cycle strobe, no stall
// config  | cfg_valid, cfg_ready, cfg_index, | write when cfg_valid && cfg_ready
//         | cfg_data                         |
// One request per clock. Each request passes through two chains of 22 restoring
// divide cells (fit size, then source coordinate) and four register stages
// (input, fit, map, output) before its result appears on done.
// busy is high only during reset; sync reset clears all valid bits.
module letterbox_nearest_scaler_map_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  panel_x,
  input  logic [8:0]  panel_y,
  output logic        done,
  output logic [1:0]  status,
  output logic        inside_res,
  output logic [11:0] src_col,
  output logic [11:0] src_row,
  output logic [23:0] src_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [11:0] sw, sh;
  logic [23:0] slen;
  logic [1:0]  stat;
  logic [23:0] area;

  lbnsm_pkg::lane_t a0, b0, a1, b1, a2, b2, a3, b3;
  lbnsm_pkg::sb_t   s0, s1, s2, s3;

  logic [9:0]  fw, fw_next;
  logic [8:0]  fh, fh_next;
  logic [9:0]  ox;
  logic [8:0]  oy;
  logic [9:0]  f_px;
  logic [8:0]  f_py;
  logic        f_vld;
  logic        ins;
  logic [9:0]  dx;
  logic [8:0]  dy;

  assign busy = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sw <= '0;
      sh <= '0;
      slen <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lbnsm_pkg::REG_WIDTH:  sw <= cfg_data[11:0];
        lbnsm_pkg::REG_HEIGHT: sh <= cfg_data[11:0];
        lbnsm_pkg::REG_LENGTH: slen <= cfg_data;
        default: ;
      endcase
    end
  end

  // status follows the registers; the user must keep them stable while requests are in flight (not enforced here)
  always_ff @(posedge clk) begin
    area <= sw * sh;
    if (sw == '0 || sh == '0) stat <= lbnsm_pkg::ST_SIZE;
    else if (slen < area) stat <= lbnsm_pkg::ST_SHORT;
    else stat <= lbnsm_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    a0.rem <= '0;
    a0.qd  <= 22'(sh) * 22'(lbnsm_pkg::PANEL_W);
    a0.dv  <= sw;
    b0.rem <= '0;
    b0.qd  <= 22'(sw) * 22'(lbnsm_pkg::PANEL_H);
    b0.dv  <= sh;
    s0.vld <= start && !busy;
    s0.in_pic <= 1'b0;
    s0.px <= panel_x;
    s0.py <= panel_y;
  end

  lbnsm_div_chain u_fit (
    .clk (clk), .rst (rst),
    .a_in (a0), .b_in (b0), .sb_in (s0),
    .a_out (a1), .b_out (b1), .sb_out (s1)
  );

  always_comb begin
    if (a1.qd > 22'(lbnsm_pkg::PANEL_H)) begin
      fh_next = 9'(lbnsm_pkg::PANEL_H);
      fw_next = b1.qd[9:0];
    end else begin
      fh_next = a1.qd[8:0];
      fw_next = 10'(lbnsm_pkg::PANEL_W);
    end
    if (fw_next == '0) fw_next = 10'd1;
    if (fh_next == '0) fh_next = 9'd1;
  end

  always_ff @(posedge clk) begin
    fw <= fw_next;
    fh <= fh_next;
    ox <= (10'(lbnsm_pkg::PANEL_W) - fw_next) >> 1;
    oy <= (9'(lbnsm_pkg::PANEL_H) - fh_next) >> 1;
    f_px <= s1.px;
    f_py <= s1.py;
    f_vld <= s1.vld && !rst;
  end

  always_comb begin
    ins = ({1'b0, f_px} >= {1'b0, ox}) && ({1'b0, f_px} < ({1'b0, ox} + {1'b0, fw}))
       && ({1'b0, f_py} >= {1'b0, oy}) && ({1'b0, f_py} < ({1'b0, oy} + {1'b0, fh}));
    dx = f_px - ox;
    dy = f_py - oy;
  end

  always_ff @(posedge clk) begin
    a2.rem <= '0;
    a2.qd  <= ins ? 22'(dx) * 22'(sw) : '0;
    a2.dv  <= {2'b0, fw};
    b2.rem <= '0;
    b2.qd  <= ins ? 22'(dy) * 22'(sh) : '0;
    b2.dv  <= {3'b0, fh};
    s2.vld <= f_vld && !rst;
    s2.in_pic <= ins;
    s2.px <= f_px;
    s2.py <= f_py;
  end

  lbnsm_div_chain u_map (
    .clk (clk), .rst (rst),
    .a_in (a2), .b_in (b2), .sb_in (s2),
    .a_out (a3), .b_out (b3), .sb_out (s3)
  );

  always_ff @(posedge clk) begin
    done <= s3.vld && !rst;
    status <= stat;
    if (stat == lbnsm_pkg::ST_OK && s3.in_pic) begin
      inside_res <= 1'b1;
      src_col <= a3.qd[11:0];
      src_row <= b3.qd[11:0];
      src_index <= ({12'b0, b3.qd[11:0]} * {12'b0, sw}) + {12'b0, a3.qd[11:0]};
    end else begin
      inside_res <= 1'b0;
      src_col <= '0;
      src_row <= '0;
      src_index <= '0;
    end
  end

endmodule

FILE: rtl/lbnsm_div_cell.sv
module lbnsm_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  lbnsm_pkg::lane_t  a_in,
  input  lbnsm_pkg::lane_t  b_in,
  input  lbnsm_pkg::sb_t    sb_in,
  output lbnsm_pkg::lane_t  a_out,
  output lbnsm_pkg::lane_t  b_out,
  output lbnsm_pkg::sb_t    sb_out
);

  lbnsm_pkg::lane_t a_next, b_next;

  function automatic lbnsm_pkg::lane_t step(input lbnsm_pkg::lane_t l);
    lbnsm_pkg::lane_t o;
    logic [lbnsm_pkg::SW:0] r;
    r = {l.rem, l.qd[lbnsm_pkg::QW-1]};
    o.dv = l.dv;
    o.qd = {l.qd[lbnsm_pkg::QW-2:0], 1'b0};
    if (r >= {1'b0, l.dv}) begin
      r = r - {1'b0, l.dv};
      o.qd[0] = 1'b1;
    end
    o.rem = r[lbnsm_pkg::SW-1:0];
    return o;
  endfunction

  always_comb begin
    a_next = step(a_in);
    b_next = step(b_in);
  end

  always_ff @(posedge clk) begin
    a_out <= a_next;
    b_out <= b_next;
    if (rst) sb_out <= '0;
    else sb_out <= sb_in;
  end

endmodule

FILE: rtl/lbnsm_div_chain.sv
module lbnsm_div_chain (
  input  logic              clk,
  input  logic              rst,
  input  lbnsm_pkg::lane_t  a_in,
  input  lbnsm_pkg::lane_t  b_in,
  input  lbnsm_pkg::sb_t    sb_in,
  output lbnsm_pkg::lane_t  a_out,
  output lbnsm_pkg::lane_t  b_out,
  output lbnsm_pkg::sb_t    sb_out
);

  lbnsm_pkg::lane_t a_c [lbnsm_pkg::NCELL+1];
  lbnsm_pkg::lane_t b_c [lbnsm_pkg::NCELL+1];
  lbnsm_pkg::sb_t   s_c [lbnsm_pkg::NCELL+1];

  assign a_c[0] = a_in;
  assign b_c[0] = b_in;
  assign s_c[0] = sb_in;

  for (genvar i = 0; i < lbnsm_pkg::NCELL; i++) begin : g_cell
    lbnsm_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .a_in   (a_c[i]),
      .b_in   (b_c[i]),
      .sb_in  (s_c[i]),
      .a_out  (a_c[i+1]),
      .b_out  (b_c[i+1]),
      .sb_out (s_c[i+1])
    );
  end

  assign a_out  = a_c[lbnsm_pkg::NCELL];
  assign b_out  = b_c[lbnsm_pkg::NCELL];
  assign sb_out = s_c[lbnsm_pkg::NCELL];

endmodule

FILE: rtl/lbnsm_checker.sv
module lbnsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic        inside_res,
  input logic [11:0] src_col,
  input logic [11:0] src_row,
  input logic [23:0] src_index
);

  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##48 done) else $error("result missing");

  a_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 48)) else $error("result without request");

  a_fault: assert property (@(posedge clk) disable iff (rst)
    (done && status != lbnsm_pkg::ST_OK) |-> !inside_res) else $error("inside on fault");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (done && !inside_res) |-> (src_col == '0 && src_row == '0 && src_index == '0))
    else $error("fill not zero");

endmodule

bind letterbox_nearest_scaler_map_unit lbnsm_checker u_chk (
  .clk (clk), .rst (rst), .start (start), .busy (busy), .done (done),
  .status (status), .inside_res (inside_res), .src_col (src_col),
  .src_row (src_row), .src_index (src_index)
);

FILE: test/tb_letterbox_nearest_scaler_map_unit.sv
module tb_letterbox_nearest_scaler_map_unit;

  typedef struct packed {
    logic [1:0]  status;
    logic        in_pic;
    logic [11:0] col;
    logic [11:0] row;
    logic [23:0] idx;
  } pixel_map_t;

  class map_scoreboard;
    logic [11:0] width_q;
    logic [11:0] height_q;
    logic [23:0] length_q;
    pixel_map_t  pending[$];
    int          errors;
    int          checked;

    function void set_reg(logic [1:0] index, logic [23:0] data);
      case (index)
        lbnsm_pkg::REG_WIDTH: width_q = data[11:0];
        lbnsm_pkg::REG_HEIGHT: height_q = data[11:0];
        lbnsm_pkg::REG_LENGTH: length_q = data;
        default: ;
      endcase
    endfunction

    function void note_request(logic [9:0] px, logic [8:0] py);
      pixel_map_t m;
      longint fw, fh, ox, oy, sw, sh;
      m = '0;
      sw = width_q;
      sh = height_q;
      if (sw == 0 || sh == 0) begin
        m.status = lbnsm_pkg::ST_SIZE;
      end else if (longint'(length_q) < sw * sh) begin
        m.status = lbnsm_pkg::ST_SHORT;
      end else begin
        m.status = lbnsm_pkg::ST_OK;
        fw = lbnsm_pkg::PANEL_W;
        fh = (sh * lbnsm_pkg::PANEL_W) / sw;
        if (fh > lbnsm_pkg::PANEL_H) begin
          fh = lbnsm_pkg::PANEL_H;
          fw = (sw * lbnsm_pkg::PANEL_H) / sh;
        end
        if (fw < 1) fw = 1;
        if (fh < 1) fh = 1;
        ox = (lbnsm_pkg::PANEL_W - fw) / 2;
        oy = (lbnsm_pkg::PANEL_H - fh) / 2;
        if (px >= ox && px < ox + fw && py >= oy && py < oy + fh) begin
          m.in_pic = 1'b1;
          m.col = 12'(((px - ox) * sw) / fw);
          m.row = 12'(((py - oy) * sh) / fh);
          m.idx = 24'(m.row * sw + m.col);
        end
      end
      pending.push_back(m);
    endfunction

    function void check_map(pixel_map_t got);
      pixel_map_t want;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.in_pic !== want.in_pic) begin
        $display("%0t: inside_res exp %0d got %0d", $time, want.in_pic, got.in_pic);
        errors++;
      end
      if (got.col !== want.col) begin
        $display("%0t: src_col exp %0d got %0d", $time, want.col, got.col);
        errors++;
      end
      if (got.row !== want.row) begin
        $display("%0t: src_row exp %0d got %0d", $time, want.row, got.row);
        errors++;
      end
      if (got.idx !== want.idx) begin
        $display("%0t: src_index exp %0d got %0d", $time, want.idx, got.idx);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [9:0]  panel_x = 0;
  logic [8:0]  panel_y = 0;
  logic        done;
  logic [1:0]  status;
  logic        inside_res;
  logic [11:0] src_col;
  logic [11:0] src_row;
  logic [23:0] src_index;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 0;
  logic [23:0] cfg_data = 0;

  map_scoreboard sb = new();
  int idle_pct;
  longint cycles;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  letterbox_nearest_scaler_map_unit DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_map({status, inside_res, src_col, src_row, src_index});
    if (cycles > 600000) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] index, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(index, data);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (lbnsm_pkg::LAT + 5) @(posedge clk);
  endtask

  task automatic set_source(int w, int h, int len);
    drain();
    write_reg(lbnsm_pkg::REG_WIDTH, 24'(w));
    write_reg(lbnsm_pkg::REG_HEIGHT, 24'(h));
    write_reg(lbnsm_pkg::REG_LENGTH, 24'(len));
    cfg_valid <= 1'b0;
  endtask

  task automatic send(logic [9:0] x, logic [8:0] y);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    panel_x <= x;
    panel_y <= y;
    do @(posedge clk); while (busy);
    sb.note_request(x, y);
  endtask

  task automatic send_random(int n);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) send(10'($urandom), 9'($urandom));
      else send(10'($urandom_range(639)), 9'($urandom_range(479)));
    end
  endtask

  int w, h, p;
  initial begin
    cycles = 0;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // size invalid at reset values
    send(0, 0);
    send(1023, 511);
    set_source(320, 240, 76800);
    send(0, 0); send(639, 479); send(320, 240); send(1023, 511);
    send(640, 0); send(0, 480);
    set_source(4095, 1, 4095);
    send(0, 239); send(639, 240); send(0, 0);
    set_source(1, 4095, 4095);
    send(319, 0); send(320, 479); send(0, 0);
    set_source(4095, 4095, 16777215);
    send(0, 0); send(639, 479); send(80, 0); send(559, 479);
    set_source(4095, 4095, 16769024);
    send(100, 100);
    set_source(0, 5, 100);
    send(5, 5);
    set_source(7, 0, 0);
    send(5, 5);
    set_source(100, 50, 4999);
    send(320, 240);
    for (p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 30 : (p == 1) ? 70 : 0;
      repeat (6) begin
        case ($urandom_range(5))
          0: begin w = $urandom_range(1, 4095); h = $urandom_range(1, 4095); end
          1: begin w = $urandom_range(1, 8); h = $urandom_range(1, 4095); end
          2: begin w = $urandom_range(1, 4095); h = $urandom_range(1, 8); end
          default: begin w = $urandom_range(1, 1000); h = $urandom_range(1, 1000); end
        endcase
        if ($urandom_range(9) == 0) set_source(w, h, w * h - 1);
        else if ($urandom_range(19) == 0) set_source(0, h, $urandom);
        else set_source(w, h, w * h + $urandom_range(0, 3) * $urandom_range(0, 999999));
        send_random(90);
      end
    end
    drain();
    $display("checked %0d results over directed fits and 18 random source sizes",
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/lbnsm_pkg.sv
rtl/lbnsm_div_cell.sv
rtl/lbnsm_div_chain.sv
rtl/letterbox_nearest_scaler_map_unit.sv
rtl/lbnsm_checker.sv
test/tb_letterbox_nearest_scaler_map_unit.sv
